// ===== rtl/lts_pkg.sv =====
// Shared constants, types and the probe pattern decoder for the line-tracking steering block.
`default_nettype none

package lts_pkg;

  localparam int SUM_W      = 24;   // integral accumulator width
  localparam int FRAC_W     = 24;   // fractional bits of ki and kd
  localparam int KP_W       = 10;
  localparam int KG_W       = 26;   // ki / kd width
  localparam int ERR_W      = 4;
  localparam int SENSOR_W   = 4;
  localparam int GYRO_W     = 16;
  localparam int STEER_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KG_W;

  // product widths: unsigned gains gain one sign bit
  localparam int PROP_W = ERR_W + KP_W + 1;
  localparam int INT_W  = SUM_W + KG_W + 1;
  localparam int GPRD_W = GYRO_W + KG_W + 1;
  localparam int TOT_W  = INT_W + 2;
  localparam int QUO_W  = TOT_W - FRAC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE_HARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_NORMAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_NORMAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_HARD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KI_HARD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_HARD   = 3'd6;

  // reset gains
  localparam logic [KP_W-1:0] KP_NORMAL_RST = 10'd450;
  localparam logic [KG_W-1:0] KI_NORMAL_RST = 26'd167772;
  localparam logic [KG_W-1:0] KD_NORMAL_RST = 26'd2516582;
  localparam logic [KP_W-1:0] KP_HARD_RST   = 10'd350;
  localparam logic [KG_W-1:0] KI_HARD_RST   = 26'd1678;
  localparam logic [KG_W-1:0] KD_HARD_RST   = 26'd2516582;

  typedef struct packed {
    logic [KP_W-1:0] kp;
    logic [KG_W-1:0] ki;
    logic [KG_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic                    hold;  // pattern not in the table: keep previous error
    logic signed [ERR_W-1:0] err;
  } pattern_t;

  // probe bits x4 x3 x2 x1 -> line error
  function automatic pattern_t decode_pattern(input logic [SENSOR_W-1:0] bits);
    pattern_t p;
    p.hold = 1'b0;
    p.err  = 4'sd0;
    case (bits)
      4'b0000, 4'b1010: p.err = 4'sd0;
      4'b0010:          p.err = 4'sd4;
      4'b0011:          p.err = 4'sd2;
      4'b0111:          p.err = 4'sd3;
      4'b1000:          p.err = -4'sd4;
      4'b1011:          p.err = 4'sd1;
      4'b1100:          p.err = -4'sd2;
      4'b1101:          p.err = -4'sd3;
      4'b1110:          p.err = -4'sd1;
      default:          p.hold = 1'b1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lts_cfg_regs.sv =====
// Gain and mode registers with selection of the active gain set.
`default_nettype none

module lts_cfg_regs
  import lts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output      gains_t                gains
);

  logic            mode_hard;
  logic [KP_W-1:0] kp_normal;
  logic [KG_W-1:0] ki_normal;
  logic [KG_W-1:0] kd_normal;
  logic [KP_W-1:0] kp_hard;
  logic [KG_W-1:0] ki_hard;
  logic [KG_W-1:0] kd_hard;
  logic            wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_hard <= 1'b0;
      kp_normal <= KP_NORMAL_RST;
      ki_normal <= KI_NORMAL_RST;
      kd_normal <= KD_NORMAL_RST;
      kp_hard   <= KP_HARD_RST;
      ki_hard   <= KI_HARD_RST;
      kd_hard   <= KD_HARD_RST;
    end else if (wr) begin
      unique case (cfg_index)
        REG_MODE_HARD: mode_hard <= cfg_data[0];
        REG_KP_NORMAL: kp_normal <= cfg_data[KP_W-1:0];
        REG_KI_NORMAL: ki_normal <= cfg_data;
        REG_KD_NORMAL: kd_normal <= cfg_data;
        REG_KP_HARD:   kp_hard   <= cfg_data[KP_W-1:0];
        REG_KI_HARD:   ki_hard   <= cfg_data;
        REG_KD_HARD:   kd_hard   <= cfg_data;
        default:       ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_comb begin
    if (mode_hard) begin
      gains.kp = kp_hard;
      gains.ki = ki_hard;
      gains.kd = kd_hard;
    end else begin
      gains.kp = kp_normal;
      gains.ki = ki_normal;
      gains.kd = kd_normal;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/line_track_pid_steer.sv =====
// Top level of the line-tracking PID steering block.
//
// Input channel: in_valid / in_stall with sensor_bits (x4..x1) and a signed
// gyro_rate sample. Each transaction yields exactly one result on the output
// channel (out_valid / out_stall) carrying steer_value and line_error.
// Configuration: cfg_valid / cfg_ready write channel, cfg_index selects the
// register, cfg_data holds the value; cfg_ready is always high. Write only
// while the block is idle.
// The first stage decodes the probe pattern, updates the integral and forms
// the three gain products; the second sums them, truncates toward zero and
// registers the result. Throughput: one transaction per cycle while out_stall
// is low.
// When the receiver holds out_stall, the result register holds and the
// stall backs up through the product stage to in_stall; once both stages
// are full, in_stall follows out_stall in the same cycle.
// Reset (rst, synchronous): clears the held error and the integral, restores
// the default gains and mode, empties the pipeline; in_stall is high during
// reset.
`default_nettype none

module line_track_pid_steer
  import lts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [SENSOR_W-1:0]       sensor_bits,
  input  wire logic signed [GYRO_W-1:0]  gyro_rate,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic signed [STEER_W-1:0] steer_value,
  output      logic signed [ERR_W-1:0]   line_error,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_MIN = (SUM_W+1)'(-SUM_MAX - 1);
  localparam logic [TOT_W-1:0] FRAC_MASK = TOT_W'((64'd1 << FRAC_W) - 1);

  gains_t gains;

  lts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  // handshake control
  logic in_acc;
  logic out_load;
  logic s1_valid;

  assign out_load = ~out_valid | ~out_stall;
  assign in_stall = rst | (s1_valid & ~out_load);
  assign in_acc   = in_valid & ~in_stall;

  // stage 1: pattern decode, integral, products
  pattern_t                pat;
  logic signed [ERR_W-1:0] held_error;
  logic signed [ERR_W-1:0] err_next;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [PROP_W-1:0] prop_next;
  logic signed [INT_W-1:0]  int_next;
  logic signed [GPRD_W-1:0] gprd_next;

  always_comb begin
    pat      = decode_pattern(sensor_bits);
    err_next = pat.hold ? held_error : pat.err;
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err_next);
    if (sum_wide > SUM_MAX) begin
      sum_next = SUM_MAX[SUM_W-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_next = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    prop_next = PROP_W'(err_next) * PROP_W'(signed'({1'b0, gains.kp}));
    int_next  = INT_W'(sum_next) * INT_W'(signed'({1'b0, gains.ki}));
    gprd_next = GPRD_W'(gyro_rate) * GPRD_W'(signed'({1'b0, gains.kd}));
  end

  logic signed [ERR_W-1:0]  s1_err;
  logic signed [PROP_W-1:0] s1_prop;
  logic signed [INT_W-1:0]  s1_int;
  logic signed [GPRD_W-1:0] s1_gprd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_error <= '0;
      error_sum  <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= in_acc | (s1_valid & ~out_load);
      if (in_acc) begin
        held_error <= err_next;
        error_sum  <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err  <= err_next;
      s1_prop <= prop_next;
      s1_int  <= int_next;
      s1_gprd <= gprd_next;
    end
  end

  // stage 2: sum, truncate toward zero
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] biased;
  logic signed [QUO_W-1:0] quo;

  always_comb begin
    total  = (TOT_W'(s1_prop) <<< FRAC_W) + TOT_W'(s1_int) + TOT_W'(s1_gprd);
    // negative values take a bias so that the shift rounds toward zero
    biased = total + signed'(total[TOT_W-1] ? FRAC_MASK : '0);
    quo    = biased[TOT_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid | (out_valid & out_stall);
    end
  end

  // the quotient always lies inside the 32-bit range, so it only sign-extends
  always_ff @(posedge clk) begin
    if (s1_valid && out_load) begin
      steer_value <= STEER_W'(quo);
      line_error  <= s1_err;
    end
  end

  // checks
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_error >= -4'sd4 && line_error <= 4'sd4))
    else $error("line error outside -4..4");

  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(error_sum) && $stable(held_error))
    else $error("integral moved without a transaction");

  a_sum_step: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> ((SUM_W+1)'(error_sum) - (SUM_W+1)'($past(error_sum)) <= 5'sd4 &&
                (SUM_W+1)'(error_sum) - (SUM_W+1)'($past(error_sum)) >= -5'sd4))
    else $error("integral step larger than the error range");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("result dropped while stalled");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> s1_valid && $stable(s1_err) && $stable(s1_int))
    else $error("product stage lost its contents while blocked");

endmodule

`default_nettype wire
